FILE: sv/nearest_sensor_on_sphere_top_assert.svh
// Assertion macros shared by the search block.
`ifndef NEAREST_SENSOR_ON_SPHERE_TOP_ASSERT_SVH
`define NEAREST_SENSOR_ON_SPHERE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NSOS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NSOS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/nsos_pkg.sv
// Types and constants for the nearest sensor search block.
package nsos_pkg;

	localparam int COS_W     = 18;
	localparam int SLOT_W    = 15;
	localparam int COUNT_W   = 16;
	localparam int PROD_W    = 2 * COS_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 2;

	typedef logic signed [COS_W-1:0] cos_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// Table entry: x in the low bits, z in the high bits.
	typedef struct packed {
		cos_t z;
		cos_t y;
		cos_t x;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam cos_t COS_MAX = COS_W'(65536);
	localparam cos_t COS_MIN = -COS_W'(65536);

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIT_COSINE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_COSINE  = 2'd2;

	// floor(sum / 2^16), clamped to [-1.0, +1.0] in Q1.16
	function automatic cos_t sat_cos(input acc_t acc);
		acc_t sh;
		sh = acc >>> FRAC_W;
		if (sh > ACC_W'(COS_MAX))
			return COS_MAX;
		else if (sh < ACC_W'(COS_MIN))
			return COS_MIN;
		else
			return sh[COS_W-1:0];
	endfunction

endpackage

FILE: sv/nsos_if.sv
// Query and result channel interfaces.
interface nsos_query_if
	import nsos_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               command;
	logic [SLOT_W-1:0]  entry_index;
	cos_t               dir_x;
	cos_t               dir_y;
	cos_t               dir_z;

	modport source (output valid, command, entry_index, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, command, entry_index, dir_x, dir_y, dir_z, output ready);
endinterface

interface nsos_result_if
	import nsos_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [SLOT_W-1:0]  sensor_index;
	cos_t               best_cosine;

	modport source (output valid, hit, sensor_index, best_cosine, input ready);
	modport sink (input valid, hit, sensor_index, best_cosine, output ready);
endinterface

FILE: sv/nsos_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module nsos_ram #(
	parameter int WIDTH = 54,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: sv/nearest_sensor_on_sphere_top.sv
// Nearest sensor search: sensor table, shared multiplier and walk sequencer.
//
//  channel  | side   | word
//  ---------+--------+------------------------------------------------
//  query    | sink   | command, entry_index, dir_x, dir_y, dir_z
//  result   | source | hit, sensor_index, best_cosine
//  cfg      | write  | cfg_index selects count / hit / skip cosine
//
// A search visits entries below min(sensor_count, TABLE_DEPTH); each gets a
// RAM read, three products through the one 18x18 multiplier, final add, compare.
// Reset clears control and config; table contents stay undefined, no sweep.
// A finished result waits in the output register; the next word is taken
// meanwhile, and a later search holds in its done state until the slot frees.
`include "nearest_sensor_on_sphere_top_assert.svh"

module nearest_sensor_on_sphere_top
	import nsos_pkg::*;
#(
	parameter int TABLE_DEPTH = 32768,
	parameter int SKIP_STRIDE = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COS_W-1:0]     cfg_data,
	nsos_query_if.sink           query,
	nsos_result_if.source        result
);

	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int IW_RAW = $clog2(TABLE_DEPTH + SKIP_STRIDE) + 1;
	localparam int IW     = (IW_RAW > COUNT_W + 1) ? IW_RAW : COUNT_W + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MX   = 3'd2;
	localparam logic [2:0] ST_MY   = 3'd3;
	localparam logic [2:0] ST_MZ   = 3'd4;
	localparam logic [2:0] ST_ADD  = 3'd5;
	localparam logic [2:0] ST_EVAL = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]         state_q;
	logic [COUNT_W-1:0] count_q;
	cos_t               hit_cos_q;
	cos_t               skip_cos_q;

	cos_t               dx_q, dy_q, dz_q;
	logic [IW-1:0]      i_q;
	logic [IW-1:0]      limit_q;
	prod_t              prod_q;
	acc_t               acc_q;
	cos_t               best_q;
	logic [AW-1:0]      best_idx_q;

	logic               res_hit_q;
	logic [SLOT_W-1:0]  res_idx_q;
	cos_t               res_best_q;

	logic               out_valid_q;
	logic               out_hit_q;
	logic [SLOT_W-1:0]  out_idx_q;
	cos_t               out_best_q;

	logic               accept;
	logic               load_ok;
	logic [IW-1:0]      slot_w;
	logic [IW-1:0]      count_w;
	logic [IW-1:0]      new_limit;
	entry_t             rdata;
	cos_t               mul_a, mul_b;
	cos_t               cos_now;
	logic               take;
	cos_t               nbest;
	logic [AW-1:0]      nbest_idx;
	logic [IW-1:0]      next_i;
	logic               slot_free;

	assign accept    = query.valid && query.ready;
	assign query.ready = (state_q == ST_IDLE);
	assign slot_w    = IW'(query.entry_index);
	assign count_w   = IW'(count_q);
	assign new_limit = (count_w > IW'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH) : count_w;
	assign load_ok   = accept && (query.command == CMD_LOAD) && (slot_w < IW'(TABLE_DEPTH));
	assign slot_free = !out_valid_q || result.ready;

	nsos_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (load_ok),
		.waddr (slot_w[AW-1:0]),
		.wdata ({query.dir_z, query.dir_y, query.dir_x}),
		.re    (state_q == ST_RD),
		.raddr (i_q[AW-1:0]),
		.rdata (rdata)
	);

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_MY: begin
				mul_a = dy_q;
				mul_b = rdata.y;
			end
			ST_MZ: begin
				mul_a = dz_q;
				mul_b = rdata.z;
			end
			default: begin
				mul_a = dx_q;
				mul_b = rdata.x;
			end
		endcase
	end

	// entry evaluation
	always_comb begin
		cos_now   = sat_cos(acc_q);
		take      = (i_q == '0) || (cos_now > best_q);
		nbest     = take ? cos_now : best_q;
		nbest_idx = take ? i_q[AW-1:0] : best_idx_q;
		next_i    = i_q + ((cos_now < skip_cos_q) ? IW'(SKIP_STRIDE) : IW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			hit_cos_q  <= COS_MAX;
			skip_cos_q <= COS_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENSOR_COUNT: count_q    <= cfg_data[COUNT_W-1:0];
				REG_HIT_COSINE:   hit_cos_q  <= cfg_data;
				REG_SKIP_COSINE:  skip_cos_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && query.command == CMD_SEARCH)
						state_q <= (new_limit == '0) ? ST_DONE : ST_RD;
				end
				ST_RD:   state_q <= ST_MX;
				ST_MX:   state_q <= ST_MY;
				ST_MY:   state_q <= ST_MZ;
				ST_MZ:   state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_EVAL;
				ST_EVAL: begin
					if (nbest >= hit_cos_q || next_i >= limit_q)
						state_q <= ST_DONE;
					else
						state_q <= ST_RD;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q       <= query.dir_x;
			dy_q       <= query.dir_y;
			dz_q       <= query.dir_z;
			i_q        <= '0;
			limit_q    <= new_limit;
			best_q     <= COS_MIN;
			best_idx_q <= '0;
			res_hit_q  <= 1'b0;
			res_idx_q  <= '0;
			res_best_q <= COS_MIN;
		end
		if (state_q == ST_MX || state_q == ST_MY || state_q == ST_MZ)
			prod_q <= mul_a * mul_b;
		if (state_q == ST_MY)
			acc_q <= ACC_W'(prod_q);
		else if (state_q == ST_MZ || state_q == ST_ADD)
			acc_q <= acc_q + ACC_W'(prod_q);
		if (state_q == ST_EVAL) begin
			best_q     <= nbest;
			best_idx_q <= nbest_idx;
			i_q        <= next_i;
			res_best_q <= nbest;
			res_hit_q  <= (nbest >= hit_cos_q);
			res_idx_q  <= (nbest >= hit_cos_q) ? SLOT_W'(nbest_idx) : '0;
		end
		if (state_q == ST_DONE && slot_free) begin
			out_hit_q  <= res_hit_q;
			out_idx_q  <= res_idx_q;
			out_best_q <= res_best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.hit          = out_hit_q;
	assign result.sensor_index = out_idx_q;
	assign result.best_cosine  = out_best_q;

	`NSOS_ASSERT_NXT(a_word_from_done, !out_valid_q || result.ready,
		!out_valid_q || $past(state_q == ST_DONE), "result word not loaded from done state")
	`NSOS_ASSERT_IMP(a_hit_reached, out_valid_q && out_hit_q,
		out_best_q >= hit_cos_q, "hit reported below hit cosine")
	`NSOS_ASSERT_IMP(a_miss_index, out_valid_q && !out_hit_q,
		out_idx_q == '0, "miss carries nonzero sensor index")
	`NSOS_ASSERT_IMP(a_walk_bound, state_q == ST_RD,
		i_q < limit_q, "walk reads past sensor count")

endmodule

FILE: tb/tb_nearest_sensor_on_sphere_top.sv
// Testbench for the nearest sensor search: table loads, directed searches and random phases.
module tb_nearest_sensor_on_sphere_top;
	import nsos_pkg::*;

	localparam int TABLE_DEPTH    = 32768;
	localparam int SKIP_STRIDE    = 10;
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_WORDS    = 20;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 16;
	localparam int TIMEOUT_CYCLES = 1000000;
	localparam longint COS_TOP    = 65536;
	localparam longint COS_BOTTOM = -65536;

	// cfg_index 3 has no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] sensor_index;
		cos_t              best_cosine;
	} match_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COS_W-1:0]     cfg_data;

	nsos_query_if  query_ch();
	nsos_result_if result_ch();

	nearest_sensor_on_sphere_top #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.SKIP_STRIDE(SKIP_STRIDE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.query(query_ch),
		.result(result_ch)
	);

	// shadow of the table and registers
	entry_t sensor_dirs [TABLE_DEPTH];
	bit     loaded [TABLE_DEPTH];
	int     count_reg;
	longint hit_reg;
	longint skip_reg;

	match_t pending_matches [$];
	int     mismatch_count = 0;
	bit     idle_on;
	int     sink_hold = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#(TIMEOUT_CYCLES * 20);
		$display("[nearest_sensor_on_sphere_top] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// walk the shadow table; returns 0 if the walk would touch an unloaded entry
	function automatic bit predict_match(input cos_t qx, input cos_t qy, input cos_t qz,
			output match_t m);
		int     limit;
		int     i;
		int     best_idx;
		longint acc;
		longint c;
		longint best;
		bit     have_best;
		bit     clean;
		bit     found;
		entry_t e;
		limit = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
		i = 0;
		best_idx = 0;
		best = COS_BOTTOM;
		have_best = 1'b0;
		clean = 1'b1;
		found = 1'b0;
		while (i < limit) begin
			if (!loaded[i])
				clean = 1'b0;
			e = sensor_dirs[i];
			acc = longint'(qx) * longint'($signed(e.x)) + longint'(qy) * longint'($signed(e.y))
				+ longint'(qz) * longint'($signed(e.z));
			c = acc >>> 16;
			if (c > COS_TOP)
				c = COS_TOP;
			else if (c < COS_BOTTOM)
				c = COS_BOTTOM;
			if (!have_best || c > best) begin
				have_best = 1'b1;
				best = c;
				best_idx = i;
			end
			if (best >= hit_reg) begin
				found = 1'b1;
				break;
			end
			i += (c < skip_reg) ? SKIP_STRIDE : 1;
		end
		m.hit = found;
		m.sensor_index = found ? SLOT_W'(best_idx) : '0;
		m.best_cosine = cos_t'(best);
		return clean;
	endfunction

	function automatic entry_t make_dir(input int x, input int y, input int z);
		entry_t d;
		d.x = cos_t'(x);
		d.y = cos_t'(y);
		d.z = cos_t'(z);
		return d;
	endfunction

	function automatic cos_t rand_comp();
		return cos_t'(int'($urandom_range(0, 131072)) - 65536);
	endfunction

	function automatic entry_t rand_dir();
		real    a;
		real    b;
		real    c;
		real    n;
		entry_t d;
		case ($urandom_range(0, 9))
			0: begin
				d = make_dir(rand_comp(), rand_comp(), rand_comp());
			end
			1: begin
				d = make_dir((int'($urandom_range(0, 2)) - 1) * 65536,
					(int'($urandom_range(0, 2)) - 1) * 65536,
					(int'($urandom_range(0, 2)) - 1) * 65536);
			end
			default: begin
				a = $itor(rand_comp());
				b = $itor(rand_comp());
				c = $itor(rand_comp());
				n = $sqrt(a * a + b * b + c * c);
				if (n < 1.0)
					d = make_dir(65536, 0, 0);
				else
					d = make_dir($rtoi(a * 65536.0 / n), $rtoi(b * 65536.0 / n),
						$rtoi(c * 65536.0 / n));
			end
		endcase
		return d;
	endfunction

	function automatic int jitter(input cos_t v);
		int r;
		r = int'(v) + int'($urandom_range(0, 4000)) - 2000;
		if (r > 65536)
			r = 65536;
		else if (r < -65536)
			r = -65536;
		return r;
	endfunction

	// query close to a table entry in the search range, so hits show up
	function automatic entry_t near_dir();
		entry_t base;
		int     lim;
		lim = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
		base = sensor_dirs[$urandom_range(0, lim - 1)];
		return make_dir(jitter(base.x), jitter(base.y), jitter(base.z));
	endfunction

	task automatic send_word(input logic cmd, input logic [SLOT_W-1:0] slot, input entry_t d);
		int     gap;
		match_t m;
		if (cmd == CMD_SEARCH) begin
			if (!predict_match(d.x, d.y, d.z, m))
				return;
		end
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			query_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		query_ch.valid <= 1'b1;
		query_ch.command <= cmd;
		query_ch.entry_index <= slot;
		query_ch.dir_x <= d.x;
		query_ch.dir_y <= d.y;
		query_ch.dir_z <= d.z;
		@(posedge clk);
		while (!query_ch.ready)
			@(posedge clk);
		if (cmd == CMD_LOAD) begin
			sensor_dirs[slot] = d;
			loaded[slot] = 1'b1;
		end else begin
			pending_matches = {pending_matches, m};
		end
	endtask

	// park the query side, wait for every result, then let a trailing load finish
	task automatic drain_matches();
		@(negedge clk);
		query_ch.valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COS_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_SENSOR_COUNT: count_reg = int'(data[COUNT_W-1:0]);
			REG_HIT_COSINE:   hit_reg = longint'($signed(data));
			REG_SKIP_COSINE:  skip_reg = longint'($signed(data));
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		match_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_matches.size() == 0) begin
				report_mismatch("unexpected word, best_cosine",
					longint'(result_ch.best_cosine), 0);
			end else begin
				want = pending_matches.pop_front();
				if (result_ch.hit !== want.hit)
					report_mismatch("hit", longint'(result_ch.hit), longint'(want.hit));
				if (result_ch.sensor_index !== want.sensor_index)
					report_mismatch("sensor_index", longint'(result_ch.sensor_index),
						longint'(want.sensor_index));
				if (result_ch.best_cosine !== want.best_cosine)
					report_mismatch("best_cosine", longint'(result_ch.best_cosine),
						longint'(want.best_cosine));
			end
		end
	end

	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			result_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			sink_hold = $urandom_range(0, 5);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// reset values: nothing in range, so a miss at the floor cosine
	task automatic test_empty_walk();
		send_word(CMD_SEARCH, SLOT_W'($urandom()), rand_dir());
		send_word(CMD_SEARCH, '1, make_dir(-65536, 65536, -65536));
	endtask

	task automatic test_table_extremes();
		send_word(CMD_LOAD, SLOT_W'(0), make_dir(65536, 0, 0));
		send_word(CMD_LOAD, SLOT_W'(1), make_dir(0, 65536, 0));
		send_word(CMD_LOAD, SLOT_W'(2), make_dir(0, 0, 65536));
		send_word(CMD_LOAD, SLOT_W'(3), make_dir(-65536, 0, 0));
		send_word(CMD_LOAD, SLOT_W'(4), make_dir(65536, 65536, 65536));
		send_word(CMD_LOAD, SLOT_W'(5), make_dir(-65536, -65536, -65536));
		send_word(CMD_LOAD, SLOT_W'(6), make_dir(-3, 5, -7));
		// same as entry 1: a tie must keep the earlier entry
		send_word(CMD_LOAD, SLOT_W'(7), make_dir(0, 65536, 0));
		send_word(CMD_LOAD, SLOT_W'(8), make_dir(46341, 46341, 0));
		send_word(CMD_LOAD, SLOT_W'(9), make_dir(0, 0, -65536));
		send_word(CMD_LOAD, SLOT_W'(10), make_dir(0, -65536, 0));
		send_word(CMD_LOAD, SLOT_W'(11), make_dir(65536, -65536, 65536));
		drain_matches();
		// upper bits of the count word are ignored
		write_reg(REG_SENSOR_COUNT, 18'h3000C);
		write_reg(REG_HIT_COSINE, cos_t'(65536));
		write_reg(REG_SKIP_COSINE, cos_t'(-65536));
		send_word(CMD_SEARCH, SLOT_W'(0), make_dir(65536, 0, 0));
		// saturates low on entry 4, high on entry 5
		send_word(CMD_SEARCH, SLOT_W'(0), make_dir(-65536, -65536, -65536));
		send_word(CMD_SEARCH, SLOT_W'($urandom()), make_dir(0, 65536, 0));
		// tiny products: negative sums floor away from zero
		send_word(CMD_SEARCH, SLOT_W'($urandom()), make_dir(5, -3, 11));
	endtask

	task automatic test_clamped_count();
		drain_matches();
		write_reg(REG_SENSOR_COUNT, 18'h3FFFF);
		write_reg(REG_HIT_COSINE, cos_t'(-65536));
		write_reg(REG_UNUSED, COS_W'($urandom()));
		send_word(CMD_SEARCH, SLOT_W'($urandom()), rand_dir());
	endtask

	task automatic test_skip_walk();
		drain_matches();
		write_reg(REG_SENSOR_COUNT, 18'd12);
		write_reg(REG_HIT_COSINE, cos_t'(65536));
		write_reg(REG_SKIP_COSINE, cos_t'(65536));
		// every entry below +1.0 skips: only 0 and 10 are visited
		send_word(CMD_SEARCH, SLOT_W'(0), make_dir(0, -65536, 0));
		send_word(CMD_SEARCH, SLOT_W'(0), make_dir(0, 0, 65536));
		drain_matches();
		write_reg(REG_SKIP_COSINE, cos_t'(0));
		send_word(CMD_SEARCH, SLOT_W'($urandom()), rand_dir());
	endtask

	task automatic test_random_phases();
		int     new_count;
		int     pause_at;
		int     slot;
		cos_t   hit_val;
		cos_t   skip_val;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_on = (p != RANDOM_PHASES - 1);
			drain_matches();
			new_count = (p == 1) ? $urandom_range(0, 3) : $urandom_range(8, 48);
			for (int i = 0; i < new_count; i++) begin
				if (!loaded[i])
					send_word(CMD_LOAD, SLOT_W'(i), rand_dir());
			end
			drain_matches();
			case ($urandom_range(0, 5))
				0:       hit_val = cos_t'(65536);
				1:       hit_val = cos_t'(-65536);
				2:       hit_val = rand_comp();
				default: hit_val = cos_t'($urandom_range(50000, 65536));
			endcase
			case ($urandom_range(0, 3))
				0:       skip_val = cos_t'(-65536);
				1:       skip_val = cos_t'(65536);
				2:       skip_val = rand_comp();
				default: skip_val = cos_t'(-int'($urandom_range(0, 65536)));
			endcase
			write_reg(REG_SENSOR_COUNT, {2'($urandom_range(0, 3)), 16'(new_count)});
			write_reg(REG_HIT_COSINE, hit_val);
			write_reg(REG_SKIP_COSINE, skip_val);
			pause_at = $urandom_range(0, PHASE_WORDS - 1);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (k == pause_at)
					drain_matches();
				if ($urandom_range(0, 99) < 65) begin
					if (count_reg > 0 && $urandom_range(0, 9) < 6)
						send_word(CMD_SEARCH, SLOT_W'($urandom()), near_dir());
					else
						send_word(CMD_SEARCH, SLOT_W'($urandom()), rand_dir());
				end else begin
					if ($urandom_range(0, 4) == 0)
						slot = $urandom_range(0, TABLE_DEPTH - 1);
					else
						slot = $urandom_range(0, new_count + 3);
					send_word(CMD_LOAD, SLOT_W'(slot), rand_dir());
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		query_ch.valid = 1'b0;
		query_ch.command = CMD_LOAD;
		query_ch.entry_index = '0;
		query_ch.dir_x = '0;
		query_ch.dir_y = '0;
		query_ch.dir_z = '0;
		count_reg = 0;
		hit_reg = COS_TOP;
		skip_reg = COS_BOTTOM;
		idle_on = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_walk();
		test_table_extremes();
		test_clamped_count();
		test_skip_walk();
		test_random_phases();

		drain_matches();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_matches.size() != 0)
			report_mismatch("words never returned", pending_matches.size(), 0);
		if (mismatch_count == 0)
			$display("[nearest_sensor_on_sphere_top] OK");
		else
			$display("[nearest_sensor_on_sphere_top] ERROR");
		$finish;
	end

endmodule
